[hdl/qmdd_pkg.sv]
// Shared types, constants and helper functions for the QAM min-distance demapper.
// No dependencies; imported by qmdd_dist_unit and qam_min_distance_demapper_core.
`default_nettype none

package qmdd_pkg;

    // table and field geometry
    localparam int MAX_POINTS = 64;
    localparam int PT_IDX_W   = $clog2(MAX_POINTS);
    localparam int LABEL_W    = 6;
    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int SQ_W       = 2 * DIFF_W - 1;
    localparam int DIST_W     = SQ_W + 1;
    localparam int BPS_W      = 3;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b1;

    // command and mode codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_DEMAP = 1'b1;
    localparam logic MODE_HARD = 1'b0;
    localparam logic MODE_BIT  = 1'b1;

    // constellation order codes
    localparam logic [1:0] ORD_QPSK  = 2'd0;
    localparam logic [1:0] ORD_QAM16 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_PACK,
        ST_FLUSH
    } t_state;

    // one point read from the table, headed into the distance unit
    typedef struct packed {
        logic                       valid;
        logic [PT_IDX_W-1:0]        label;
        logic signed [SAMPLE_W-1:0] pt_i;
        logic signed [SAMPLE_W-1:0] pt_q;
    } t_pt_rd;

    // one squared distance leaving the distance unit
    typedef struct packed {
        logic                valid;
        logic [PT_IDX_W-1:0] label;
        logic [DIST_W-1:0]   sqd;
    } t_dist_out;

    // label bits per symbol, unused order code saturates to 64-QAM
    function automatic logic [BPS_W-1:0] bits_per_sym(input logic [1:0] order);
        case (order)
            ORD_QPSK:  bits_per_sym = 3'd2;
            ORD_QAM16: bits_per_sym = 3'd4;
            default:   bits_per_sym = 3'd6;
        endcase
    endfunction

    // highest label that takes part in a decision
    function automatic logic [PT_IDX_W-1:0] last_point(input logic [1:0] order);
        case (order)
            ORD_QPSK:  last_point = PT_IDX_W'(3);
            ORD_QAM16: last_point = PT_IDX_W'(15);
            default:   last_point = PT_IDX_W'(MAX_POINTS - 1);
        endcase
    endfunction

endpackage

`default_nettype wire

[hdl/qam_min_distance_demapper_core.sv]
// Top level of the QAM min-distance demapper: point table, sequencer, minima, bit packer.
// Depends on qmdd_pkg and qmdd_dist_unit.
//
// A load word (cmd 0) writes one constellation point and busy stays low, so loads can be
// issued back to back. A demap word (cmd 1) makes the block walk the first 4, 16 or 64
// table entries through one pipelined distance unit, one point per cycle, keeping the
// nearest point and the per-bit class minima in the same pass. A symbol holds busy
// through the table walk, the distance pipeline drain, the decision state and the packer,
// which shifts out the label bits, plus the flush state when it flushes a partial byte.
// Each result byte is shown on o_out_byte / o_last_byte for exactly one cycle with
// o_out_valid high; the receiver cannot stall it, and a symbol gives at most two bytes.
// Configuration is always ready and takes effect on the next symbol; write it only while
// busy is low.
`default_nettype none

module qam_min_distance_demapper_core
    import qmdd_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // command channel
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_cmd,
    input  wire logic [LABEL_W-1:0]         i_point_label,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_i,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_q,
    input  wire logic                       i_last_symbol,
    // configuration channel
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    // result channel
    output logic                            o_out_valid,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_byte
);

    // ---------------------------------------------------------------- registers
    t_state                      r_state, n_state;
    logic [1:0]                  r_order;
    logic                        r_mode;
    logic signed [SAMPLE_W-1:0]  r_si, n_si, r_sq, n_sq;
    logic                        r_last, n_last;
    logic [PT_IDX_W-1:0]         r_rd_idx, n_rd_idx;
    logic                        r_rd_vld, n_rd_vld;
    logic [PT_IDX_W-1:0]         r_rd_lab;
    logic [2*SAMPLE_W-1:0]       r_rd_word;
    logic [2*SAMPLE_W-1:0]       r_mem [MAX_POINTS];

    logic                        r_has_best, n_has_best;
    logic [DIST_W-1:0]           r_best, n_best;
    logic [PT_IDX_W-1:0]         r_best_lab, n_best_lab;
    logic [DIST_W-1:0]           r_min0 [LABEL_W];
    logic [DIST_W-1:0]           n_min0 [LABEL_W];
    logic [DIST_W-1:0]           r_min1 [LABEL_W];
    logic [DIST_W-1:0]           n_min1 [LABEL_W];
    logic [LABEL_W-1:0]          r_has0, n_has0, r_has1, n_has1;

    logic [LABEL_W-1:0]          r_shift, n_shift;
    logic [BPS_W-1:0]            r_bit_idx, n_bit_idx;
    logic [7:0]                  r_acc, n_acc;
    logic [2:0]                  r_fill, n_fill;
    logic                        r_out_valid, n_out_valid;
    logic [7:0]                  r_out_byte, n_out_byte;
    logic                        r_out_last, n_out_last;

    // ---------------------------------------------------------------- wires
    logic                        w_accept;
    logic                        w_cfg_we;
    t_pt_rd                      w_pt;
    t_dist_out                   w_dist;
    logic                        w_pending;
    logic [BPS_W-1:0]            w_bps;
    logic [PT_IDX_W-1:0]         w_last_pt;
    logic [LABEL_W-1:0]          w_label;
    logic                        w_bit;
    logic [7:0]                  w_acc;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_bps       = bits_per_sym(r_order);
    assign w_last_pt   = last_point(r_order);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORD_QPSK;
            r_mode  <= MODE_HARD;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_ORDER: r_order <= i_cfg_data[1:0];
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                default:   r_order <= r_order;
            endcase
        end
    end

    // point table, one write port for loads, one registered read port for the walk
    always_ff @(posedge i_clk) begin
        if (w_accept && i_cmd == CMD_LOAD) begin
            r_mem[i_point_label[PT_IDX_W-1:0]] <= {i_sample_i, i_sample_q};
        end
        r_rd_word <= r_mem[r_rd_idx];
        r_rd_lab  <= r_rd_idx;
    end

    assign w_pt.valid = r_rd_vld;
    assign w_pt.label = r_rd_lab;
    assign w_pt.pt_i  = r_rd_word[2*SAMPLE_W-1:SAMPLE_W];
    assign w_pt.pt_q  = r_rd_word[SAMPLE_W-1:0];

    // shared distance unit
    qmdd_dist_unit u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (w_pt),
        .i_sample_i (r_si),
        .i_sample_q (r_sq),
        .o_dist     (w_dist),
        .o_pending  (w_pending)
    );

    // label decision from the collected minima
    always_comb begin
        if (r_mode == MODE_HARD) begin
            w_label = r_best_lab;
        end else begin
            for (int b = 0; b < LABEL_W; b++) begin
                w_label[b] = r_has1[b] && (!r_has0[b] || (r_min1[b] < r_min0[b]));
            end
        end
    end

    // packer datapath: next label bit lands at position 7 - fill
    assign w_bit = r_shift[LABEL_W-1];
    assign w_acc = r_acc | (8'(w_bit) << (3'd7 - r_fill));

    // sequencer, minima tracking and packer
    always_comb begin
        n_state     = r_state;
        n_si        = r_si;
        n_sq        = r_sq;
        n_last      = r_last;
        n_rd_idx    = r_rd_idx;
        n_rd_vld    = 1'b0;
        n_has_best  = r_has_best;
        n_best      = r_best;
        n_best_lab  = r_best_lab;
        n_min0      = r_min0;
        n_min1      = r_min1;
        n_has0      = r_has0;
        n_has1      = r_has1;
        n_shift     = r_shift;
        n_bit_idx   = r_bit_idx;
        n_acc       = r_acc;
        n_fill      = r_fill;
        n_out_valid = 1'b0;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        // fold each arriving distance into the running minima
        if (w_dist.valid) begin
            if (!r_has_best || w_dist.sqd < r_best) begin
                n_has_best = 1'b1;
                n_best     = w_dist.sqd;
                n_best_lab = w_dist.label;
            end
            for (int b = 0; b < LABEL_W; b++) begin
                if (w_dist.label[b]) begin
                    if (!r_has1[b] || w_dist.sqd < r_min1[b]) begin
                        n_has1[b] = 1'b1;
                        n_min1[b] = w_dist.sqd;
                    end
                end else begin
                    if (!r_has0[b] || w_dist.sqd < r_min0[b]) begin
                        n_has0[b] = 1'b1;
                        n_min0[b] = w_dist.sqd;
                    end
                end
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_cmd == CMD_DEMAP) begin
                    n_si       = i_sample_i;
                    n_sq       = i_sample_q;
                    n_last     = i_last_symbol;
                    n_rd_idx   = '0;
                    n_has_best = 1'b0;
                    n_has0     = '0;
                    n_has1     = '0;
                    n_state    = ST_SCAN;
                end
            end
            // issue one table read per cycle
            ST_SCAN: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_rd_idx + 1'b1;
                if (r_rd_idx == w_last_pt) begin
                    n_state = ST_DRAIN;
                end
            end
            // wait until the last distance has been folded in
            ST_DRAIN: begin
                if (!r_rd_vld && !w_pending) begin
                    n_state = ST_DECIDE;
                end
            end
            // left-align the label so its msb goes out first
            ST_DECIDE: begin
                n_shift   = w_label << (3'(LABEL_W) - w_bps);
                n_bit_idx = '0;
                n_state   = ST_PACK;
            end
            // one label bit per cycle into the byte accumulator
            ST_PACK: begin
                n_shift   = r_shift << 1;
                n_bit_idx = r_bit_idx + 1'b1;
                if (r_fill == 3'd7) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_acc;
                    n_out_last  = r_last && (r_bit_idx == w_bps - 1'b1);
                    n_acc       = '0;
                    n_fill      = '0;
                end else begin
                    n_acc  = w_acc;
                    n_fill = r_fill + 1'b1;
                end
                if (r_bit_idx == w_bps - 1'b1) begin
                    if (r_last && n_fill != 3'd0) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            // end of block: emit the zero-padded partial byte
            ST_FLUSH: begin
                n_out_valid = 1'b1;
                n_out_byte  = r_acc;
                n_out_last  = 1'b1;
                n_acc       = '0;
                n_fill      = '0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_acc       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_has_best  <= 1'b0;
            r_has0      <= '0;
            r_has1      <= '0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_acc       <= n_acc;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_has_best  <= n_has_best;
            r_has0      <= n_has0;
            r_has1      <= n_has1;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_si       <= n_si;
        r_sq       <= n_sq;
        r_last     <= n_last;
        r_rd_idx   <= n_rd_idx;
        r_best     <= n_best;
        r_best_lab <= n_best_lab;
        r_min0     <= n_min0;
        r_min1     <= n_min1;
        r_shift    <= n_shift;
        r_bit_idx  <= n_bit_idx;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

`default_nettype wire

[hdl/qmdd_dist_unit.sv]
// Three-stage squared Euclidean distance unit: difference, square, sum.
// Depends on qmdd_pkg for widths and the t_pt_rd / t_dist_out structs.
`default_nettype none

module qmdd_dist_unit
    import qmdd_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_pt_rd                     i_pt,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_i,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_q,
    output t_dist_out                       o_dist,
    output logic                            o_pending
);

    logic                      r_v1, r_v2, r_v3;
    logic [PT_IDX_W-1:0]       r_lab1, r_lab2, r_lab3;
    logic signed [DIFF_W-1:0]  r_di, r_dq;
    logic [SQ_W-1:0]           r_sqi, r_sqq;
    logic [DIST_W-1:0]         r_dist;

    logic signed [DIFF_W-1:0]   w_di, w_dq;
    logic signed [2*DIFF_W-1:0] w_pi, w_pq;

    // sample minus point, one bit wider so it cannot overflow
    assign w_di = DIFF_W'(i_sample_i) - DIFF_W'(i_pt.pt_i);
    assign w_dq = DIFF_W'(i_sample_q) - DIFF_W'(i_pt.pt_q);

    // squares are never negative, top bit of the product is dropped
    assign w_pi = r_di * r_di;
    assign w_pq = r_dq * r_dq;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_pt.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_lab1 <= i_pt.label;
        r_di   <= w_di;
        r_dq   <= w_dq;
        r_lab2 <= r_lab1;
        r_sqi  <= w_pi[SQ_W-1:0];
        r_sqq  <= w_pq[SQ_W-1:0];
        r_lab3 <= r_lab2;
        r_dist <= DIST_W'(r_sqi) + DIST_W'(r_sqq);
    end

    assign o_dist.valid = r_v3;
    assign o_dist.label = r_lab3;
    assign o_dist.sqd   = r_dist;
    assign o_pending    = r_v1 | r_v2 | r_v3;

endmodule

`default_nettype wire
